### src/fixed_slot_pool_allocator_core_defines.svh
// Assertion helpers used by the allocator RTL.
`ifndef FIXED_SLOT_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, inactive during reset.
`define FSPA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive during reset.
`define FSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/fspa_pkg.sv
`timescale 1ns / 1ps

package fspa_pkg;

    localparam int BLOCK_BYTES = 4096;
    localparam int NUM_BLOCKS  = 16;
    localparam int FREE_DEPTH  = 8192;

    localparam int ADDR_W = 16;
    localparam int SLOT_W = 12;

    localparam int FREE_AW = $clog2(FREE_DEPTH);
    localparam int FCNT_W  = $clog2(FREE_DEPTH + 1);
    localparam int BLK_W   = $clog2(NUM_BLOCKS + 1);
    localparam int BOFF_W  = $clog2(BLOCK_BYTES + 1);
    localparam int OFF_W   = (BOFF_W > SLOT_W) ? BOFF_W : SLOT_W;
    localparam int SUM_W   = OFF_W + 1;
    localparam int BASE_W  = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
    localparam int AMAX_W  = (BASE_W > OFF_W) ? BASE_W : OFF_W;
    localparam int ASUM_W  = ((AMAX_W > ADDR_W) ? AMAX_W : ADDR_W) + 1;
    localparam int MOD_CNT_W = $clog2(BASE_W);

    // input queue, depth must stay a power of two (pointers wrap)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(8);

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_BLOCK = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MOD,
        S_OPEN
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [ADDR_W-1:0]  addr;
    } t_req;

endpackage

### src/fixed_slot_pool_allocator_core.sv
`timescale 1ns / 1ps
// Fixed-size slot pool allocator.
// Request channel (i_valid/o_ready): i_func 0 allocates a slot, 1 frees
// i_free_addr onto a LIFO free stack. Result channel (o_valid/i_ready):
// o_slot_addr and o_status (0 ok, 1 no block left, 2 free stack full),
// exactly one result per request, in request order.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): slot size in
// bytes, 0 acts as 1; write only while no request is outstanding.
// Path from request transfer to o_valid, after the request FIFO:
//   free, or allocate by bumping inside the open block: result register
//   allocate from the free stack: registered stack RAM read, result register
//   allocate that opens a new block: S_MOD, with the bit-serial remainder
//   unit (one step per bit of the 17-bit block base), S_OPEN, result register.
// Throughput: bump and free run at one per cycle while the receiver takes
// results; a stack pop or a block opening holds the queue until its result is registered.
// A two-entry request FIFO and the result register keep requests flowing
// while the receiver stalls; o_ready drops only when the FIFO fills.
// Synchronous reset: empty stack, no block open, slot size 8. The stack
// RAM is not cleared; only pushed entries are ever read.
module fixed_slot_pool_allocator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [fspa_pkg::ADDR_W-1:0]   i_free_addr,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fspa_pkg::ADDR_W-1:0]   o_slot_addr,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fspa_pkg::SLOT_W-1:0]   i_cfg_data
);

    // front to back request queue
    logic            q_valid;
    logic            q_pop;
    fspa_pkg::t_req  q_req;

    fspa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_free_addr (i_free_addr),
        .o_q_valid   (q_valid),
        .i_q_pop     (q_pop),
        .o_q_req     (q_req)
    );

    // execution: free stack, bump pointer, block opening, result register
    fspa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_req     (q_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_slot_addr (o_slot_addr),
        .o_status    (o_status)
    );

endmodule

### src/fspa_ram.sv
`timescale 1ns / 1ps

module fspa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/fspa_mod.sv
`timescale 1ns / 1ps

// Restoring remainder, one dividend bit per cycle.
module fspa_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fspa_pkg::BASE_W-1:0]   i_dividend,
    input  logic [fspa_pkg::SLOT_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [fspa_pkg::SLOT_W-1:0]   o_rem
);

    logic                              r_busy;
    logic                              r_done;
    logic [fspa_pkg::MOD_CNT_W-1:0]    r_cnt;
    logic [fspa_pkg::BASE_W-1:0]       r_div;
    logic [fspa_pkg::SLOT_W-1:0]       r_divisor;
    logic [fspa_pkg::SLOT_W-1:0]       r_rem;

    logic [fspa_pkg::SLOT_W:0]         trial;
    logic [fspa_pkg::SLOT_W:0]         dvs_ext;
    logic [fspa_pkg::SLOT_W-1:0]       n_rem;
    logic                              last_step;

    always_comb begin
        trial   = {r_rem, r_div[fspa_pkg::BASE_W-1]};
        dvs_ext = {1'b0, r_divisor};
        if (trial >= dvs_ext) begin
            n_rem = fspa_pkg::SLOT_W'(trial - dvs_ext);
        end else begin
            n_rem = trial[fspa_pkg::SLOT_W-1:0];
        end
        last_step = (r_cnt == (fspa_pkg::MOD_CNT_W)'(fspa_pkg::BASE_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div     <= i_dividend;
            r_divisor <= i_divisor;
            r_rem     <= '0;
        end else if (r_busy) begin
            r_div <= r_div << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### src/fspa_front.sv
`timescale 1ns / 1ps

// Request intake: decode and buffer in a small FIFO.
module fspa_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [fspa_pkg::ADDR_W-1:0]   i_free_addr,
    output logic                          o_q_valid,
    input  logic                          i_q_pop,
    output fspa_pkg::t_req                o_q_req
);

    fspa_pkg::t_req                  r_entry [fspa_pkg::QUEUE_DEPTH];
    logic [fspa_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [fspa_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [fspa_pkg::QCNT_W-1:0]     r_cnt;

    fspa_pkg::t_req                  in_req;
    logic                            push;

    always_comb begin
        in_req.func = fspa_pkg::t_func'(i_func);
        in_req.addr = i_free_addr;
    end

    assign o_ready   = (r_cnt != (fspa_pkg::QCNT_W)'(fspa_pkg::QUEUE_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_req   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !i_q_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_q_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= in_req;
        end
    end

endmodule

### src/fspa_back.sv
`timescale 1ns / 1ps
`include "fixed_slot_pool_allocator_core_defines.svh"

// Executes queued requests: free stack, bump pointer, block opening.
module fspa_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fspa_pkg::SLOT_W-1:0]   i_cfg_data,
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    input  fspa_pkg::t_req                i_q_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fspa_pkg::ADDR_W-1:0]   o_slot_addr,
    output logic [1:0]                    o_status
);

    fspa_pkg::t_state                  r_state, n_state;
    logic [fspa_pkg::SLOT_W-1:0]       r_slot_size;
    logic [fspa_pkg::FCNT_W-1:0]       r_free_count, n_free_count;
    logic [fspa_pkg::BLK_W-1:0]        r_blocks_used, n_blocks_used;
    logic [fspa_pkg::BASE_W-1:0]       r_next_base, n_next_base;
    logic [fspa_pkg::OFF_W-1:0]        r_cur_offset, n_cur_offset;
    logic                              r_out_valid, n_out_valid;
    logic [fspa_pkg::ADDR_W-1:0]       r_out_addr, n_out_addr;
    fspa_pkg::t_status                 r_out_status, n_out_status;

    logic [fspa_pkg::SLOT_W-1:0]       s_eff;
    logic [fspa_pkg::SUM_W-1:0]        off_sum;
    logic                              fits;
    logic [fspa_pkg::ADDR_W-1:0]       bump_addr;
    logic [fspa_pkg::FCNT_W-1:0]       cnt_dec;
    logic [fspa_pkg::SLOT_W-1:0]       pad;

    logic                              ram_we, ram_re;
    logic [fspa_pkg::ADDR_W-1:0]       ram_rdata;
    logic                              mod_start, mod_done;
    logic [fspa_pkg::SLOT_W-1:0]       mod_rem;
    logic                              q_pop;

    fspa_ram #(
        .WIDTH (fspa_pkg::ADDR_W),
        .DEPTH (fspa_pkg::FREE_DEPTH)
    ) u_free_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_count[fspa_pkg::FREE_AW-1:0]),
        .i_wdata (i_q_req.addr),
        .i_re    (ram_re),
        .i_raddr (cnt_dec[fspa_pkg::FREE_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    fspa_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_next_base),
        .i_divisor  (s_eff),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign o_cfg_ready = 1'b1;

    always_comb begin
        s_eff     = (r_slot_size == '0) ? (fspa_pkg::SLOT_W)'(1) : r_slot_size;
        off_sum   = (fspa_pkg::SUM_W)'(r_cur_offset) + (fspa_pkg::SUM_W)'(s_eff);
        fits      = (off_sum <= (fspa_pkg::SUM_W)'(fspa_pkg::BLOCK_BYTES));
        // current block base is one block below the next base
        bump_addr = fspa_pkg::ADDR_W'((fspa_pkg::ASUM_W)'(r_next_base)
                                      - (fspa_pkg::ASUM_W)'(fspa_pkg::BLOCK_BYTES)
                                      + (fspa_pkg::ASUM_W)'(r_cur_offset));
        cnt_dec   = r_free_count - 1'b1;
        pad       = (mod_rem == '0) ? '0 : (s_eff - mod_rem);
    end

    always_comb begin
        n_state       = r_state;
        n_free_count  = r_free_count;
        n_blocks_used = r_blocks_used;
        n_next_base   = r_next_base;
        n_cur_offset  = r_cur_offset;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_addr    = r_out_addr;
        n_out_status  = r_out_status;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        mod_start     = 1'b0;
        q_pop         = 1'b0;

        unique case (r_state)
            fspa_pkg::S_IDLE: begin
                if (i_q_valid && (!r_out_valid || i_ready)) begin
                    q_pop = 1'b1;
                    if (i_q_req.func == fspa_pkg::FN_FREE) begin
                        n_out_valid = 1'b1;
                        n_out_addr  = '0;
                        if (r_free_count >= (fspa_pkg::FCNT_W)'(fspa_pkg::FREE_DEPTH)) begin
                            n_out_status = fspa_pkg::ST_FULL;
                        end else begin
                            ram_we       = 1'b1;
                            n_free_count = r_free_count + 1'b1;
                            n_out_status = fspa_pkg::ST_OK;
                        end
                    end else if (r_free_count != '0) begin
                        ram_re       = 1'b1;
                        n_free_count = cnt_dec;
                        n_state      = fspa_pkg::S_READ;
                    end else if (r_blocks_used != '0 && fits) begin
                        n_out_valid  = 1'b1;
                        n_out_addr   = bump_addr;
                        n_out_status = fspa_pkg::ST_OK;
                        n_cur_offset = off_sum[fspa_pkg::OFF_W-1:0];
                    end else if (r_blocks_used >= (fspa_pkg::BLK_W)'(fspa_pkg::NUM_BLOCKS)) begin
                        n_out_valid  = 1'b1;
                        n_out_addr   = '0;
                        n_out_status = fspa_pkg::ST_NO_BLOCK;
                    end else begin
                        mod_start = 1'b1;
                        n_state   = fspa_pkg::S_MOD;
                    end
                end
            end
            fspa_pkg::S_READ: begin
                n_out_valid  = 1'b1;
                n_out_addr   = ram_rdata;
                n_out_status = fspa_pkg::ST_OK;
                n_state      = fspa_pkg::S_IDLE;
            end
            fspa_pkg::S_MOD: begin
                if (mod_done) begin
                    n_cur_offset  = (fspa_pkg::OFF_W)'(pad);
                    n_blocks_used = r_blocks_used + 1'b1;
                    n_next_base   = r_next_base + (fspa_pkg::BASE_W)'(fspa_pkg::BLOCK_BYTES);
                    n_state       = fspa_pkg::S_OPEN;
                end
            end
            fspa_pkg::S_OPEN: begin
                n_out_valid = 1'b1;
                n_state     = fspa_pkg::S_IDLE;
                if (fits) begin
                    n_out_addr   = bump_addr;
                    n_out_status = fspa_pkg::ST_OK;
                    n_cur_offset = off_sum[fspa_pkg::OFF_W-1:0];
                end else begin
                    // padded first slot overruns the block: block stays consumed
                    n_out_addr   = '0;
                    n_out_status = fspa_pkg::ST_NO_BLOCK;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fspa_pkg::S_IDLE;
            r_slot_size   <= fspa_pkg::SLOT_RESET;
            r_free_count  <= '0;
            r_blocks_used <= '0;
            r_next_base   <= '0;
            r_cur_offset  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_free_count  <= n_free_count;
            r_blocks_used <= n_blocks_used;
            r_next_base   <= n_next_base;
            r_cur_offset  <= n_cur_offset;
            r_out_valid   <= n_out_valid;
            if (i_cfg_valid) begin
                r_slot_size <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    assign o_q_pop     = q_pop;
    assign o_valid     = r_out_valid;
    assign o_slot_addr = r_out_addr;
    assign o_status    = r_out_status;

    `FSPA_ASSERT_IMPL(a_read_out_free, i_clk, i_rst_n, r_state == fspa_pkg::S_READ, !r_out_valid, "stack read while a result is pending")
    `FSPA_ASSERT_IMPL(a_mod_done_in_mod, i_clk, i_rst_n, mod_done, r_state == fspa_pkg::S_MOD, "remainder finished outside block opening")
    `FSPA_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, q_pop && i_q_req.func == fspa_pkg::FN_FREE && r_free_count < (fspa_pkg::FCNT_W)'(fspa_pkg::FREE_DEPTH), r_free_count == $past(r_free_count) + 1'b1, "free push lost")
    `FSPA_ASSERT_IMPL(a_blocks_bound, i_clk, i_rst_n, 1'b1, r_blocks_used <= (fspa_pkg::BLK_W)'(fspa_pkg::NUM_BLOCKS), "opened more blocks than exist")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import fspa_pkg::*;

    // One expected result per request, in request order.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        t_status           status;
    } t_slot_result;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Request channel. All inputs start at known values.
    logic              i_valid     = 1'b0;
    logic              i_func      = 1'b0;
    logic [ADDR_W-1:0] i_free_addr = '0;
    logic              o_ready;

    // Result channel
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [ADDR_W-1:0] o_slot_addr;
    logic [1:0]        o_status;

    // Slot size register write channel
    logic              i_cfg_valid = 1'b0;
    logic [SLOT_W-1:0] i_cfg_data  = '0;
    logic              o_cfg_ready;

    fixed_slot_pool_allocator_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_free_addr (i_free_addr),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_slot_addr (o_slot_addr),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Allocator shadow state, advanced at every request transfer.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] stack_mem [FREE_DEPTH];
    int                stack_cnt   = 0;
    int                blocks_open = 0;   // 0 means no block open yet
    int                blk_off     = 0;   // byte offset of next slot in block
    logic [SLOT_W-1:0] slot_bytes  = SLOT_RESET;

    t_slot_result      pending_results[$];
    logic [ADDR_W-1:0] live_addrs[$];     // handed out, not yet freed
    int                bad_cnt = 0;

    // Traffic shaping knobs shared with the receiver process.
    bit idle_on   = 1'b1;
    bit hold_req  = 1'b0;
    int hold_left = 0;
    int stall_left = 0;

    function automatic void predict_slot(input t_func f, input logic [ADDR_W-1:0] fa,
                                         output t_slot_result r);
        int s;
        int base;
        bit ok;
        r.addr   = '0;
        r.status = ST_OK;
        if (f == FN_FREE) begin
            if (stack_cnt >= FREE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                stack_mem[stack_cnt] = fa;
                stack_cnt++;
            end
        end else if (stack_cnt > 0) begin
            // LIFO reuse of the most recently freed address
            stack_cnt--;
            r.addr = stack_mem[stack_cnt];
        end else begin
            s  = (slot_bytes == '0) ? 1 : int'(slot_bytes);
            ok = 1'b1;
            if (blocks_open == 0 || blk_off + s > BLOCK_BYTES) begin
                if (blocks_open >= NUM_BLOCKS) begin
                    ok = 1'b0;
                end else begin
                    // open next block, pad first slot up to a slot multiple;
                    // the block is consumed even if the slot then won't fit
                    base        = blocks_open * BLOCK_BYTES;
                    blk_off     = (s - base % s) % s;
                    blocks_open++;
                    ok          = (blk_off + s <= BLOCK_BYTES);
                end
            end
            if (ok) begin
                r.addr  = ADDR_W'((blocks_open - 1) * BLOCK_BYTES + blk_off);
                blk_off = blk_off + s;
            end else begin
                r.status = ST_NO_BLOCK;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: optional gap, then hold valid until the transfer.
    // Valid is left high on return so back-to-back requests never see a
    // low/high pair in one step; callers that wait must lower it first.
    // ------------------------------------------------------------------
    task automatic issue(input t_func f, input logic [ADDR_W-1:0] fa);
        t_slot_result r;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= f;
        i_free_addr <= fa;
        do @(posedge i_clk); while (!o_ready);
        predict_slot(f, fa, r);
        pending_results.push_back(r);
        if (f == FN_ALLOC && r.status == ST_OK)
            live_addrs.push_back(r.addr);
    endtask

    // Stop offering and wait until every result has come back.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Slot size writes happen only with nothing in flight. Every request
    // yields a result, so an empty queue means the core is idle.
    task automatic cfg_write(input logic [SLOT_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        slot_bytes   = v;
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = 300;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            i_ready   <= 1'b0;
            stall_left = $urandom_range(0, 9);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every result transfer against the oldest prediction.
    // ------------------------------------------------------------------
    t_slot_result want_r;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                bad_cnt++;
                if (bad_cnt <= 10)
                    $display("ERROR: result transfer with nothing pending: addr %h status %0d",
                             o_slot_addr, o_status);
            end else begin
                want_r = pending_results.pop_front();
                if (o_slot_addr !== want_r.addr) begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display("ERROR: slot_addr expected %h got %h", want_r.addr, o_slot_addr);
                end
                if (o_status !== want_r.status) begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display("ERROR: status expected %0d got %0d (addr %h)",
                                 want_r.status, o_status, want_r.addr);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset slot size of 8: first allocate opens block 0, LIFO reuse,
    // duplicate frees, extreme addresses.
    task automatic test_default_slot();
        issue(FN_ALLOC, 16'hFFFF);
        issue(FN_ALLOC, 16'h0000);
        issue(FN_FREE, 16'hFFFF);
        issue(FN_FREE, 16'h0000);
        issue(FN_FREE, 16'h0000);
        issue(FN_ALLOC, 16'($urandom));
        issue(FN_ALLOC, 16'($urandom));
        issue(FN_ALLOC, 16'($urandom));
        issue(FN_ALLOC, 16'($urandom));
    endtask

    // Size 0 acts as a 1-byte slot.
    task automatic test_zero_slot();
        cfg_write('0);
        issue(FN_ALLOC, 16'($urandom));
        issue(FN_ALLOC, 16'($urandom));
        issue(FN_FREE, 16'hA5A5);
        issue(FN_ALLOC, 16'($urandom));
    endtask

    // Half-block slot (2048 bytes): one slot still fits in block 0, then a block opening.
    task automatic test_max_slot();
        cfg_write(SLOT_W'(2048));
        repeat (3) issue(FN_ALLOC, 16'($urandom));
    endtask

    // All-ones slot size: padding leaves no room, block consumed, status 1.
    task automatic test_oversize_slot();
        cfg_write('1);
        repeat (2) issue(FN_ALLOC, 16'($urandom));
    endtask

    // Non power of two slot: first slot padded to a slot multiple.
    task automatic test_pad_align();
        cfg_write(SLOT_W'(1000));
        repeat (2) issue(FN_ALLOC, 16'($urandom));
    endtask

    // Receiver holds off while requests keep coming, so the input stalls.
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (12) begin
            issue(FN_FREE, 16'($urandom));
            issue(FN_ALLOC, 16'($urandom));
        end
        drain();
        idle_on = 1'b1;
    endtask

    // Phases of random traffic, one slot size each. Frees mostly return
    // addresses that were handed out; the rest are arbitrary values.
    task automatic test_random_mix();
        int sz;
        int free_pct;
        int k;
        logic [ADDR_W-1:0] a;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       sz = 0;
                1:       sz = 8;
                2:       sz = $urandom_range(1, 64);
                3:       sz = $urandom_range(65, 255);
                4:       sz = $urandom_range(1024, 2048);
                5:       sz = $urandom_range(1, 32);
                6:       sz = $urandom_range(2, 16);
                default: sz = $urandom_range(1, 8);
            endcase
            // big slots burn blocks fast: keep the stack busier there
            free_pct = (ph == 4) ? 50 : 40;
            cfg_write(SLOT_W'(sz));
            idle_on = (ph != 3 && ph != 7);
            repeat (180) begin
                if ($urandom_range(0, 99) < free_pct) begin
                    if (live_addrs.size() > 0 && $urandom_range(0, 9) < 8) begin
                        k = $urandom_range(0, live_addrs.size() - 1);
                        a = live_addrs[k];
                        live_addrs.delete(k);
                    end else begin
                        a = 16'($urandom);
                    end
                    issue(FN_FREE, a);
                end else begin
                    issue(FN_ALLOC, 16'($urandom));
                end
            end
        end
        idle_on = 1'b0;
    endtask

    // Burn the remaining blocks, then allocate with none left.
    task automatic test_blocks_exhausted();
        cfg_write('1);
        while (blocks_open < NUM_BLOCKS) issue(FN_ALLOC, 16'($urandom));
        repeat (3) issue(FN_ALLOC, 16'($urandom));
        issue(FN_FREE, 16'h1234);
        issue(FN_ALLOC, 16'($urandom));
        issue(FN_ALLOC, 16'($urandom));
        // small slot may still fit in the tail of the last block
        cfg_write(SLOT_W'(8));
        repeat (3) issue(FN_ALLOC, 16'($urandom));
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_slot();
        test_zero_slot();
        test_max_slot();
        test_oversize_slot();
        test_pad_align();
        test_backpressure();
        test_random_mix();
        test_blocks_exhausted();

        drain();
        // a block opening may still be finishing; leave room for a stray result
        repeat (40) @(posedge i_clk);
        if (bad_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hang guard, far above the slowest legal run.
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
